// ===== rtl/sgm_pkg.sv =====
// Shared constants and state types of the Sobel gradient magnitude block.
// No dependencies; every other file imports this package.
package sgm_pkg;

    localparam int GRAD_W = 11;
    localparam int MAG_W  = 11;
    localparam int POS_W  = 10;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] DIM_RESET  = 11'd512;
    localparam logic [CFG_W-1:0] DIM_MIN    = 11'd3;
    localparam logic [CFG_W-1:0] HEIGHT_MAX = 11'd1024;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_CALC = 2'b10
    } front_state_t;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_SQUARE = 5'b00010,
        B_SUM    = 5'b00100,
        B_ROOT   = 5'b01000,
        B_DONE   = 5'b10000
    } back_state_t;

endpackage

// ===== rtl/sobel_gradient_magnitude_core.sv =====
// Streaming 3x3 Sobel gradient magnitude over a raster pixel stream.
//
// Pixels enter on in_valid/in_ready with pixel, in raster order. Each
// interior pixel gives one item on out_valid/out_ready: both gradients,
// the floor of their Euclidean magnitude, the centre position and a
// frame_end mark on the last interior pixel. Border pixels give no item.
// The item for a centre pixel follows acceptance of the pixel below and
// right of it. frame_width and frame_height are written through
// cfg_we/cfg_index/cfg_data; any such write restarts the frame at row 0.
// The front end takes one pixel at a time: line store read, then window
// update, which waits while the queue is full. The back end handles one
// result at a time (take, square, sum, one root bit per cycle, output);
// a two-entry queue between them absorbs short bursts. A stalled receiver
// holds its item on the outputs; pixels keep entering until the queue fills.
// Reset sets both dimensions to 512 and the position to row 0, column 0;
// the line stores are not cleared and need no clearing pass.
// Depends on sgm_pkg, sgm_front, sgm_queue and sgm_back.
module sobel_gradient_magnitude_core
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIXEL_BITS-1:0] pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GRAD_W-1:0]     grad_h,
    output logic [GRAD_W-1:0]     grad_v,
    output logic [MAG_W-1:0]      magnitude,
    output logic [POS_W-1:0]      out_row,
    output logic [POS_W-1:0]      out_col,
    output logic                  frame_end
);

    localparam int DW = 2 * (PIXEL_BITS + 3) + 2 * POS_W + 1;

    logic          push_valid, push_ready;
    logic [DW-1:0] push_data;
    logic          pop_valid, pop_ready;
    logic [DW-1:0] pop_data;

    sgm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sgm_queue #(
        .DW (DW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sgm_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad_h    (grad_h),
        .grad_v    (grad_v),
        .magnitude (magnitude),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

endmodule

// ===== rtl/sgm_front.sv =====
// Front end: frame registers, line stores, 3x3 window and the two gradients.
// Depends on sgm_pkg; pushes one entry per interior pixel into sgm_queue.
module sgm_front
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PIXEL_BITS-1:0]         pixel,
    output logic                          push_valid,
    input  logic                          push_ready,
    output logic [2*(PIXEL_BITS+3)+2*POS_W:0] push_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int GW = PIXEL_BITS + 3;
    localparam int SW = PIXEL_BITS + 2;
    localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

    front_state_t            state_reg;
    logic [CFG_W-1:0]        fw_reg;
    logic [CFG_W-1:0]        fh_reg;
    logic [CW-1:0]           col_reg;
    logic [POS_W-1:0]        row_reg;
    logic [PIXEL_BITS-1:0]   px_reg;
    logic [PIXEL_BITS-1:0]   up_rd_reg;
    logic [PIXEL_BITS-1:0]   lo_rd_reg;
    logic [PIXEL_BITS-1:0]   window_reg [6];
    logic [PIXEL_BITS-1:0]   upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]   lower_mem [MAX_WIDTH];

    logic [12:0]             fw13;
    logic [12:0]             w_eff;
    logic [CFG_W-1:0]        h_eff;
    logic                    last_col;
    logic                    last_row;
    logic                    produce;
    logic                    accept;
    logic                    advance;
    logic                    cfg_hit;
    logic [SW-1:0]           left_sum, right_sum, top_sum, bot_sum;
    logic signed [GW-1:0]    gh, gv;
    logic [CW-1:0]           col_m1;
    logic [POS_W-1:0]        row_m1;

    assign fw13  = 13'(fw_reg);
    assign w_eff = (fw13 < 13'(DIM_MIN)) ? 13'(DIM_MIN) : ((fw13 > MAXW) ? MAXW : fw13);
    assign h_eff = (fh_reg < DIM_MIN) ? DIM_MIN : ((fh_reg > HEIGHT_MAX) ? HEIGHT_MAX : fh_reg);

    assign last_col = (13'(col_reg) == w_eff - 13'd1);
    assign last_row = (CFG_W'(row_reg) == h_eff - 11'd1);
    assign produce  = (row_reg >= POS_W'(2)) && (32'(col_reg) >= 32'd2);

    assign in_ready   = (state_reg == F_IDLE);
    assign accept     = in_valid && in_ready;
    assign push_valid = (state_reg == F_CALC) && produce;
    assign advance    = (state_reg == F_CALC) && (!produce || push_ready);
    assign cfg_hit    = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    // Window columns: left is entries 0..2, middle is 3..5; the right column
    // comes from the two line stores and the incoming pixel.
    assign left_sum  = SW'(window_reg[0]) + (SW'(window_reg[1]) << 1) + SW'(window_reg[2]);
    assign right_sum = SW'(up_rd_reg) + (SW'(lo_rd_reg) << 1) + SW'(px_reg);
    assign top_sum   = SW'(window_reg[0]) + (SW'(window_reg[3]) << 1) + SW'(up_rd_reg);
    assign bot_sum   = SW'(window_reg[2]) + (SW'(window_reg[5]) << 1) + SW'(px_reg);
    assign gh = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
    assign gv = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});

    assign col_m1 = col_reg - CW'(1);
    assign row_m1 = row_reg - POS_W'(1);
    assign push_data = {gh, gv, row_m1, POS_W'(col_m1), last_col && last_row};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[col_reg];
            lo_rd_reg <= lower_mem[col_reg];
        end
        if (advance)
        begin
            upper_mem[col_reg] <= lo_rd_reg;
            lower_mem[col_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fw_reg    <= DIM_RESET;
            fh_reg    <= DIM_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 6; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_CALC;
                    end
                end
                F_CALC:
                begin
                    if (advance)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase

            if (advance)
            begin
                window_reg[0] <= window_reg[3];
                window_reg[1] <= window_reg[4];
                window_reg[2] <= window_reg[5];
                window_reg[3] <= up_rd_reg;
                window_reg[4] <= lo_rd_reg;
                window_reg[5] <= px_reg;
            end

            if (cfg_hit)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                begin
                    fw_reg <= cfg_data;
                end
                else
                begin
                    fh_reg <= cfg_data;
                end
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (advance)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + POS_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/sgm_queue.sv =====
// Two-entry queue between the front end and the square-root back end.
// Depends on sgm_pkg only for the common import style.
module sgm_queue
    import sgm_pkg::*;
#(
    parameter int DW = 43
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/sgm_back.sv =====
// Back end: squares the gradients and takes the integer square root, two
// radicand bits per cycle, then holds the saturated result for the output channel.
// Depends on sgm_pkg.
module sgm_back
    import sgm_pkg::*;
#(
    parameter int PIXEL_BITS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [2*(PIXEL_BITS+3)+2*POS_W:0] pop_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [GRAD_W-1:0]              grad_h,
    output logic [GRAD_W-1:0]              grad_v,
    output logic [MAG_W-1:0]               magnitude,
    output logic [POS_W-1:0]               out_row,
    output logic [POS_W-1:0]               out_col,
    output logic                           frame_end
);

    localparam int GW  = PIXEL_BITS + 3;
    localparam int AW  = PIXEL_BITS + 2;
    localparam int NB  = PIXEL_BITS + 3;
    localparam int VW  = 2 * NB;
    localparam int SQW = 2 * AW;
    localparam int XW  = (GW > GRAD_W) ? GW : GRAD_W;
    localparam int MW  = (NB > MAG_W) ? NB : MAG_W;
    localparam int KW  = $clog2(NB + 1);

    back_state_t           state_reg;
    logic signed [GW-1:0]  gh_reg, gv_reg;
    logic [POS_W-1:0]      row_reg, col_reg;
    logic                  end_reg;
    logic [SQW-1:0]        sq_h_reg, sq_v_reg;
    logic [VW-1:0]         val_reg;
    logic [NB+1:0]         rem_reg;
    logic [NB-1:0]         root_reg;
    logic [KW-1:0]         cnt_reg;

    logic [AW-1:0]         abs_h, abs_v;
    logic [NB+2:0]         rem_sh, trial;
    logic                  fits;
    logic signed [XW-1:0]  gh_x, gv_x;
    logic [MW-1:0]         root_x;

    assign pop_ready = (state_reg == B_IDLE);
    assign out_valid = (state_reg == B_DONE);

    assign abs_h = gh_reg[GW-1] ? AW'(-gh_reg) : AW'(gh_reg);
    assign abs_v = gv_reg[GW-1] ? AW'(-gv_reg) : AW'(gv_reg);

    assign rem_sh = {rem_reg[NB:0], val_reg[VW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    assign gh_x   = XW'(gh_reg);
    assign gv_x   = XW'(gv_reg);
    assign root_x = MW'(root_reg);

    assign grad_h = (gh_x > XW'(1023)) ? GRAD_W'(1023) :
                    ((gh_x < -XW'(1024)) ? GRAD_W'(-1024) : GRAD_W'(gh_x));
    assign grad_v = (gv_x > XW'(1023)) ? GRAD_W'(1023) :
                    ((gv_x < -XW'(1024)) ? GRAD_W'(-1024) : GRAD_W'(gv_x));
    assign magnitude = (root_x > MW'(2047)) ? MAG_W'(2047) : MAG_W'(root_x);
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign frame_end = end_reg;

    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            {gh_reg, gv_reg, row_reg, col_reg, end_reg} <= pop_data;
        end
        if (state_reg == B_SQUARE)
        begin
            sq_h_reg <= abs_h * abs_h;
            sq_v_reg <= abs_v * abs_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            val_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= B_SQUARE;
                    end
                end
                B_SQUARE:
                begin
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    val_reg   <= VW'(sq_h_reg) + VW'(sq_v_reg);
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    // One result bit per cycle, two radicand bits consumed.
                    val_reg <= {val_reg[VW-3:0], 2'b00};
                    if (fits)
                    begin
                        rem_reg  <= (NB+2)'(rem_sh - trial);
                        root_reg <= {root_reg[NB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= (NB+2)'(rem_sh);
                        root_reg <= {root_reg[NB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + KW'(1);
                    if (cnt_reg == KW'(NB - 1))
                    begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/sobel_gradient_magnitude_core_tb.sv =====
// Self-checking testbench for sobel_gradient_magnitude_core.
// Depends on sgm_pkg and the block's RTL; a scoreboard class predicts each result.
`timescale 1ns / 100ps

module sobel_gradient_magnitude_core_tb;
    import sgm_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 64;
    localparam int RANDOM_ITEMS = 340;

    // Register indexes that the block does not implement.
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [GRAD_W-1:0] grad_h;
        logic [GRAD_W-1:0] grad_v;
        logic [MAG_W-1:0]  magnitude;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } gradient_t;

    class GradientScoreboard;
        bit [7:0]     upper_line[MAX_W];
        bit [7:0]     lower_line[MAX_W];
        bit [7:0]     win[6];
        int           row_pos;
        int           col_pos;
        bit [CFG_W-1:0] width_reg;
        bit [CFG_W-1:0] height_reg;
        gradient_t    pending_q[$];
        int           errors;

        function new();
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
            foreach (win[i]) win[i] = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            if (idx == REG_FRAME_WIDTH) width_reg = d;
            else if (idx == REG_FRAME_HEIGHT) height_reg = d;
            else return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int clamp(int v, int hi);
            return (v < 3) ? 3 : ((v > hi) ? hi : v);
        endfunction

        function int root_floor(int unsigned v);
            int unsigned res;
            int unsigned bits;
            res  = 0;
            bits = 1 << 30;
            while (bits > v) bits >>= 2;
            while (bits != 0) begin
                if (v >= res + bits) begin
                    v   = v - (res + bits);
                    res = (res >> 1) + bits;
                end
                else res >>= 1;
                bits >>= 2;
            end
            return res;
        endfunction

        function int sat(int v);
            return (v > 1023) ? 1023 : ((v < -1024) ? -1024 : v);
        endfunction

        function void note_pixel(bit [7:0] px);
            int w, h, c, r, gh, gv, mag;
            bit [7:0] rt, rm;
            gradient_t g;
            w = clamp(width_reg, MAX_W);
            h = clamp(height_reg, 1024);
            c = (col_pos >= w) ? w - 1 : col_pos;
            r = (row_pos >= h) ? h - 1 : row_pos;
            rt = upper_line[c];
            rm = lower_line[c];
            if (r >= 2 && c >= 2) begin
                gh = (win[0] + 2 * win[1] + win[2]) - (rt + 2 * rm + px);
                gv = (win[0] + 2 * win[3] + rt) - (win[2] + 2 * win[5] + px);
                mag = root_floor(gh * gh + gv * gv);
                if (mag > 2047) mag = 2047;
                g.grad_h    = GRAD_W'(sat(gh));
                g.grad_v    = GRAD_W'(sat(gv));
                g.magnitude = MAG_W'(mag);
                g.row       = POS_W'(r - 1);
                g.col       = POS_W'(c - 1);
                g.last      = (r == h - 1 && c == w - 1);
                pending_q.push_back(g);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = rt;
            win[4] = rm;
            win[5] = px;
            upper_line[c] = rm;
            lower_line[c] = px;
            if (c >= w - 1) begin
                col_pos = 0;
                row_pos = (r >= h - 1) ? 0 : r + 1;
            end
            else begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(gradient_t got);
            gradient_t exp_g;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected item at row %0d col %0d", got.row, got.col));
                return;
            end
            exp_g = pending_q.pop_front();
            if (got.grad_h !== exp_g.grad_h)
                report($sformatf("grad_h %0d, expected %0d at %0d,%0d", $signed(got.grad_h),
                    $signed(exp_g.grad_h), exp_g.row, exp_g.col));
            if (got.grad_v !== exp_g.grad_v)
                report($sformatf("grad_v %0d, expected %0d at %0d,%0d", $signed(got.grad_v),
                    $signed(exp_g.grad_v), exp_g.row, exp_g.col));
            if (got.magnitude !== exp_g.magnitude)
                report($sformatf("magnitude %0d, expected %0d at %0d,%0d", got.magnitude,
                    exp_g.magnitude, exp_g.row, exp_g.col));
            if (got.row !== exp_g.row || got.col !== exp_g.col)
                report($sformatf("position %0d,%0d, expected %0d,%0d", got.row, got.col,
                    exp_g.row, exp_g.col));
            if (got.last !== exp_g.last)
                report($sformatf("frame_end %0b, expected %0b at %0d,%0d", got.last,
                    exp_g.last, exp_g.row, exp_g.col));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [7:0]        pixel = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [GRAD_W-1:0] grad_h;
    logic [GRAD_W-1:0] grad_v;
    logic [MAG_W-1:0]  magnitude;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              frame_end;

    GradientScoreboard sb = new();

    int cycle_count = 0;
    int burst_left = 0;
    bit steady_sender = 0;
    int rx_mode = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int random_sent = 0;

    sobel_gradient_magnitude_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad_h    (grad_h),
        .grad_v    (grad_v),
        .magnitude (magnitude),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Values read here are the ones present just before the edge.
    always @(posedge clk)
    begin
        gradient_t got;
        if (rst_n) begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.note_pixel(pixel);
            if (out_valid && out_ready) begin
                got.grad_h    = grad_h;
                got.grad_v    = grad_v;
                got.magnitude = magnitude;
                got.row       = out_row;
                got.col       = out_col;
                got.last      = frame_end;
                sb.check_result(got);
            end
        end
    end

    // Receiver: a long hold-off when asked, otherwise a stall pattern of its own.
    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (cycle_count % 5 != 0);
            endcase
        end
    end

    task send_pixel(input bit [7:0] px);
        int gap;
        if (burst_left == 0) begin
            gap = steady_sender ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        pixel    <= px;
        do @(posedge clk); while (!in_ready);
    endtask

    task wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it once after a series of writes.
    task cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Nine pixels of a 3x3 frame, first pixel in the top byte.
    task send_tile(input bit [71:0] tile);
        for (int i = 8; i >= 0; i--) send_pixel(tile[i*8 +: 8]);
    endtask

    function bit [7:0] pick_pixel(int style);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(100, 140));
        endcase
    endfunction

    initial
    begin
        int w, h, n, style, phase;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed 3x3 frames: flat, strongest edges of both signs, corners.
        set_frame(11'd3, 11'd3);
        send_tile({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_tile({8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
        send_tile({8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF});
        send_tile({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_tile({8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'h00, 8'h00, 8'h00, 8'hAA});

        // Out-of-range sizes clamp to the minimum.
        set_frame(11'd0, 11'd1);
        for (int i = 0; i < 18; i++) send_pixel(pick_pixel(0));

        // Unknown register indexes are ignored without restarting the frame.
        set_frame(11'd4, 11'd2);
        for (int i = 0; i < 6; i++) send_pixel(pick_pixel(0));
        wait_idle();
        cfg_write(REG_SPARE_A, 11'h7FF);
        cfg_write(REG_SPARE_B, 11'h000);
        cfg_we <= 1'b0;
        @(posedge clk);
        for (int i = 0; i < 18; i++) send_pixel(pick_pixel(1));

        // Largest width register value; part of a row, then a restart.
        set_frame(11'h7FF, 11'd3);
        steady_sender = 1;
        for (int i = 0; i < 40; i++) send_pixel(pick_pixel(0));
        steady_sender = 0;

        // Tallest frame, cut short by the next write.
        set_frame(11'd3, 11'h7FF);
        for (int i = 0; i < 30; i++) send_pixel(pick_pixel(0));
        set_frame(11'd1024, 11'd1024);
        for (int i = 0; i < 8; i++) send_pixel(pick_pixel(0));

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_frame(CFG_W'(w), CFG_W'(h));
            w = (w < 3) ? 3 : w;
            h = (h < 3) ? 3 : h;
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 2 * w);
            steady_sender = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 2);
            if (phase == 0) hold_requests++;
            for (int i = 0; i < n; i++) begin
                if (phase == 1 && i == n / 2) begin
                    in_valid <= 1'b0;
                    burst_left = 0;
                    while (sb.pending_q.size() != 0) @(posedge clk);
                end
                send_pixel(pick_pixel(style));
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end
        else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
